// File: hdl/mvap_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the crc-16/mcrf4xx byte fold for the attitude frame parser
// no dependencies
package mvap_pkg;

    localparam logic [7:0]  SYNC_BYTE       = 8'hFE;
    localparam logic [7:0]  WANTED_ID_RESET = 8'd30;
    localparam logic [7:0]  CRC_EXTRA_RESET = 8'd39;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;

    // register indexes, taken from paddr[2]
    localparam logic REG_WANTED_ID = 1'b0;
    localparam logic REG_CRC_EXTRA = 1'b1;

    typedef enum logic [8:0] {
        PH_HUNT    = 9'b000000001,
        PH_LEN     = 9'b000000010,
        PH_SEQ     = 9'b000000100,
        PH_SYS     = 9'b000001000,
        PH_COMP    = 9'b000010000,
        PH_MSG     = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CRCLO   = 9'b010000000,
        PH_CRCHI   = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [7:0] wanted_message_id;
        logic [7:0] crc_extra_byte;
    } t_cfg;

    typedef struct packed {
        logic        crc_ok;
        logic [31:0] roll_bits;
        logic [31:0] pitch_bits;
    } t_att_result;

    // one byte through the reflected 0x1021 crc
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
               ^ {12'h000, t[7:4]};
    endfunction

endpackage

// File: hdl/mvap_intf.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: received bytes in, attitude results out
// no dependencies
interface mvap_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mvap_att_if;
    logic        valid;
    logic        ready;
    logic        crc_ok;
    logic [31:0] roll_bits;
    logic [31:0] pitch_bits;

    modport source (output valid, output crc_ok, output roll_bits, output pitch_bits,
                    input ready);
    modport sink   (input valid, input crc_ok, input roll_bits, input pitch_bits,
                    output ready);
endinterface

// File: hdl/mvap_cfg_regs.sv
`timescale 1ns / 1ps
// apb-style configuration registers: wanted message id and crc extra byte
// depends on mvap_pkg
module mvap_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mvap_pkg::t_cfg    o_cfg
);
    import mvap_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_write;

    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            unique case (paddr[2])
                REG_WANTED_ID: n_cfg.wanted_message_id = pwdata[7:0];
                REG_CRC_EXTRA: n_cfg.crc_extra_byte    = pwdata[7:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WANTED_ID: prdata = {24'h000000, r_cfg.wanted_message_id};
            REG_CRC_EXTRA: prdata = {24'h000000, r_cfg.crc_extra_byte};
            default:       prdata = 32'h00000000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wanted_message_id <= WANTED_ID_RESET;
            r_cfg.crc_extra_byte    <= CRC_EXTRA_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: hdl/mvap_frame_fsm.sv
`timescale 1ns / 1ps
// frame phase machine, running crc and roll/pitch capture, one byte per cycle while i_fire is high
// depends on mvap_pkg
module mvap_frame_fsm (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [7:0]             i_byte,
    input  mvap_pkg::t_cfg         i_cfg,
    output logic                   o_res_valid,
    output mvap_pkg::t_att_result  o_res
);
    import mvap_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_idx, n_idx;
    logic        r_match, n_match;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_lo, n_lo;
    logic [31:0] r_roll, n_roll;
    logic [31:0] r_pitch, n_pitch;

    logic [15:0] w_crc_b;
    logic [15:0] w_crc_bx;
    logic [7:0]  w_idx_inc;
    logic        w_ok;

    assign w_crc_b   = crc_fold(r_crc, i_byte);
    assign w_crc_bx  = crc_fold(w_crc_b, i_cfg.crc_extra_byte);
    assign w_idx_inc = r_idx + 8'd1;
    assign w_ok      = ({i_byte, r_lo} == r_crc);

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_idx   = r_idx;
        n_match = r_match;
        n_crc   = r_crc;
        n_lo    = r_lo;
        n_roll  = r_roll;
        n_pitch = r_pitch;
        o_res_valid      = 1'b0;
        o_res.crc_ok     = w_ok;
        o_res.roll_bits  = w_ok ? r_roll  : 32'h00000000;
        o_res.pitch_bits = w_ok ? r_pitch : 32'h00000000;
        if (i_fire) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte == SYNC_BYTE) begin
                        n_crc   = CRC_INIT;
                        n_roll  = 32'h00000000;
                        n_pitch = 32'h00000000;
                        n_idx   = 8'd0;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len   = i_byte;
                    n_crc   = w_crc_b;
                    n_phase = PH_SEQ;
                end
                PH_SEQ: begin
                    n_crc   = w_crc_b;
                    n_phase = PH_SYS;
                end
                PH_SYS: begin
                    n_crc   = w_crc_b;
                    n_phase = PH_COMP;
                end
                PH_COMP: begin
                    n_crc   = w_crc_b;
                    n_phase = PH_MSG;
                end
                PH_MSG: begin
                    n_match = (i_byte == i_cfg.wanted_message_id);
                    n_idx   = 8'd0;
                    // empty payload: extra byte goes in right after the id
                    if (r_len == 8'd0) begin
                        n_crc   = w_crc_bx;
                        n_phase = PH_CRCLO;
                    end else begin
                        n_crc   = w_crc_b;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    // bytes 4..7 are roll, 8..11 pitch, little-endian
                    if (r_idx[7:4] == 4'd0 && r_idx[3:2] == 2'd1) begin
                        n_roll[{r_idx[1:0], 3'b000} +: 8] =
                            r_roll[{r_idx[1:0], 3'b000} +: 8] | i_byte;
                    end else if (r_idx[7:4] == 4'd0 && r_idx[3:2] == 2'd2) begin
                        n_pitch[{r_idx[1:0], 3'b000} +: 8] =
                            r_pitch[{r_idx[1:0], 3'b000} +: 8] | i_byte;
                    end
                    n_idx = w_idx_inc;
                    if (w_idx_inc == r_len) begin
                        n_crc   = w_crc_bx;
                        n_phase = PH_CRCLO;
                    end else begin
                        n_crc   = w_crc_b;
                    end
                end
                PH_CRCLO: begin
                    n_lo    = i_byte;
                    n_phase = PH_CRCHI;
                end
                PH_CRCHI: begin
                    o_res_valid = r_match;
                    n_phase     = PH_HUNT;
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= 8'd0;
            r_idx   <= 8'd0;
            r_match <= 1'b0;
            r_crc   <= CRC_INIT;
            r_lo    <= 8'd0;
            r_roll  <= 32'h00000000;
            r_pitch <= 32'h00000000;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_match <= n_match;
            r_crc   <= n_crc;
            r_lo    <= n_lo;
            r_roll  <= n_roll;
            r_pitch <= n_pitch;
        end
    end

    a_hi_back_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == PH_CRCHI) |=> (r_phase == PH_HUNT))
        else $error("phase did not return to hunt after checksum high byte");

    a_sync_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == PH_HUNT && i_byte == SYNC_BYTE)
        |=> (r_crc == CRC_INIT && r_roll == 32'h0 && r_pitch == 32'h0))
        else $error("sync did not restart crc and captures");

    a_result_only_at_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_phase == PH_HUNT && $stable(r_crc)))
        else $error("result issued outside checksum high byte");

endmodule

// File: hdl/mvap_out_stage.sv
`timescale 1ns / 1ps
// result register with one skid entry toward the output channel
// depends on mvap_pkg and mvap_intf
module mvap_out_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_res_valid,
    input  mvap_pkg::t_att_result  i_res,
    output logic                   o_in_ready,
    mvap_att_if.source             out_ch
);
    import mvap_pkg::*;

    logic        r_main_v, n_main_v;
    logic        r_skid_v, n_skid_v;
    t_att_result r_main, n_main;
    t_att_result r_skid, n_skid;
    logic        w_drain;

    assign w_drain           = r_main_v && out_ch.ready;
    assign o_in_ready        = !r_skid_v;
    assign out_ch.valid      = r_main_v;
    assign out_ch.crc_ok     = r_main.crc_ok;
    assign out_ch.roll_bits  = r_main.roll_bits;
    assign out_ch.pitch_bits = r_main.pitch_bits;

    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        n_main   = r_main;
        n_skid   = r_skid;
        priority if (r_skid_v) begin
            if (w_drain) begin
                n_main   = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (r_main_v && !w_drain) begin
            if (i_res_valid) begin
                n_skid   = i_res;
                n_skid_v = 1'b1;
            end
        end else begin
            n_main_v = i_res_valid;
            if (i_res_valid) begin
                n_main = i_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid entry held while output register empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !out_ch.ready) |=> (r_skid_v && $stable(r_skid)))
        else $error("skid entry lost while output stalled");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && out_ch.ready) |=> (r_main_v && !r_skid_v && r_main == $past(r_skid)))
        else $error("skid entry not moved into output register");

endmodule

// File: hdl/mavlink_v1_attitude_frame_parser.sv
`timescale 1ns / 1ps
// top level of the mavlink v1 attitude frame parser
// depends on mvap_pkg, mvap_intf, mvap_cfg_regs, mvap_frame_fsm, mvap_out_stage
//
// usage:
//   in_ch carries one received byte per transaction; out_ch carries one result
//   (crc_ok, roll_bits, pitch_bits) for each frame whose id matches the
//   wanted id register, issued on the checksum high byte
//   frames with other ids are skipped by their length byte with no result
//   a failed checksum gives crc_ok low with roll and pitch zero
// config: apb-style, register 0 wanted message id at 0x0, register 1 crc extra
//   byte at 0x4; write only while idle; pready always high
// result: registered into the output register, or into the skid entry while that
//   register is held, on the checksum high byte transaction
// throughput: one byte per cycle while in_ch.ready is high; the only loop is the per-byte
//   crc fold and phase step, computed combinationally from the registered state
// stall: the output register plus one skid entry keep bytes flowing while a
//   result waits; in_ch.ready drops only when both hold results
// reset: i_rst_n synchronous active low; hunt for sync, registers to 30 and 39,
//   both output entries empty
module mavlink_v1_attitude_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mvap_byte_if.sink   in_ch,
    mvap_att_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mvap_pkg::*;

    t_cfg        w_cfg;
    logic        w_fire;
    logic        w_res_valid;
    t_att_result w_res;
    logic        w_in_ready;

    // a byte transaction completes on valid and ready together
    assign in_ch.ready = w_in_ready;
    assign w_fire      = in_ch.valid && w_in_ready;

    // configuration registers
    mvap_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // phase machine, crc and capture: one byte per cycle while in_ch.ready is high
    mvap_frame_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_byte      (in_ch.rx_byte),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register and skid entry
    mvap_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_in_ready  (w_in_ready),
        .out_ch      (out_ch)
    );

endmodule
